// ----- sv/prp_pkg.sv -----
`default_nettype none

package prp_pkg;

	// Input opcodes
	localparam logic [2:0] OP_MOTION      = 3'd0;
	localparam logic [2:0] OP_STEP_DEF    = 3'd1;
	localparam logic [2:0] OP_STEP_SNIPE  = 3'd2;
	localparam logic [2:0] OP_SET_SNIPE   = 3'd3;
	localparam logic [2:0] OP_TOG_SNIPE   = 3'd4;
	localparam logic [2:0] OP_SET_DRAG    = 3'd5;
	localparam logic [2:0] OP_TOG_DRAG    = 3'd6;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNIPE_BASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SNIPE_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_RES   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_DEF_BASE   = 16'd400;
	localparam logic [11:0] RST_DEF_STEP   = 12'd200;
	localparam logic [15:0] RST_SNIPE_BASE = 16'd200;
	localparam logic [11:0] RST_SNIPE_STEP = 12'd100;
	localparam logic [15:0] RST_DRAG_RES   = 16'd100;
	localparam logic [7:0]  RST_THRESHOLD  = 8'd6;
	localparam logic [1:0]  RST_REVERSE    = 2'd0;

	localparam int unsigned ACC_W = 10;

	// One axis of the drag-scroll buffer after a motion word
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             emit;
		logic             neg;
	} axis_t;

endpackage

`default_nettype wire

// ----- sv/pointer_resolution_and_drag_scroll.sv -----
// Pointer mode controller with drag-scroll for a trackball.
// Input channel: in_valid / in_stall with opcode, forward, pressed, dx, dy,
// wheel_h_in, wheel_v_in. A word is taken at a clock edge with in_valid high
// and in_stall low. Every input word yields exactly one result word on the
// output channel out_valid / out_stall (resolution, out_x/y/h/v, mode flags
// and indices), in order.
// Path: a taken word sits in the input register, is processed into the
// output register, and is then offered on the output channel.
// Throughput: one word per cycle unless stalled; all work is one short
// combinational pass (4x12 and 2x12 multiplies, two 17-bit saturating adds,
// two 11-bit buffer adds and compares) between input and output registers.
// Stall: when out_stall holds a full output register, the output word holds,
// the input register holds its word, and in_stall rises until space frees.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0..6) at the
// clock edge; write only while no word is in flight.
// Reset (arst_n low): registers return to defaults (400, 200, 200, 100, 100,
// 6, 0), indices, flags and scroll buffers clear, and both stages empty.
`default_nettype none

module pointer_resolution_and_drag_scroll
	import prp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           opcode,
	input  wire logic                 forward,
	input  wire logic                 pressed,
	input  wire logic signed [7:0]    dx,
	input  wire logic signed [7:0]    dy,
	input  wire logic signed [7:0]    wheel_h_in,
	input  wire logic signed [7:0]    wheel_v_in,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [15:0]               resolution,
	output logic signed [7:0]         out_x,
	output logic signed [7:0]         out_y,
	output logic signed [7:0]         out_h,
	output logic signed [7:0]         out_v,
	output logic                      sniping_on,
	output logic                      drag_on,
	output logic [3:0]                default_index,
	output logic [1:0]                sniping_index
);

	// Add one move to a buffer; clear it and flag a scroll once its
	// magnitude exceeds the threshold.
	function automatic axis_t drag_axis(input logic [ACC_W-1:0] acc,
			input logic [7:0] d, input logic rev, input logic [7:0] thr);
		logic signed [ACC_W:0] dext;
		logic signed [ACC_W:0] sum;
		logic signed [ACC_W:0] thr_s;
		axis_t r;
		dext  = (ACC_W+1)'($signed(d));
		thr_s = $signed({{(ACC_W-7){1'b0}}, thr});
		sum   = $signed({acc[ACC_W-1], acc}) + (rev ? -dext : dext);
		r.neg = sum[ACC_W];
		if (sum > thr_s || sum < -thr_s) begin
			r.emit = 1'b1;
			r.acc  = '0;
		end else begin
			r.emit = 1'b0;
			r.acc  = sum[ACC_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic [15:0] def_base_q, snipe_base_q, drag_res_q;
	logic [11:0] def_step_q, snipe_step_q;
	logic [7:0]  thresh_q;
	logic [1:0]  reverse_q;

	// Mode state
	logic [3:0]       def_idx_q;
	logic [1:0]       snipe_idx_q;
	logic             snipe_flag_q, drag_flag_q;
	logic [ACC_W-1:0] acc_h_q, acc_v_q;

	// Input register
	logic       vld_s1;
	logic [2:0] op_s1;
	logic       fwd_s1, prs_s1;
	logic [7:0] dx_s1, dy_s1, wh_s1, wv_s1;

	// Output register
	logic        vld_s2;
	logic [15:0] res_s2;
	logic [7:0]  x_s2, y_s2, h_s2, v_s2;
	logic        snipe_s2, drag_s2;
	logic [3:0]  didx_s2;
	logic [1:0]  sidx_s2;

	logic out_free, adv_s1, take_in;

	// Next state and result of the word in the input register
	logic [3:0]       def_idx_n;
	logic [1:0]       snipe_idx_n;
	logic             snipe_flag_n, drag_flag_n;
	logic [ACC_W-1:0] acc_h_n, acc_v_n;
	logic [7:0]       ox, oy, oh, ov;
	axis_t            ax_h, ax_v;
	logic [15:0]      def_prod;
	logic [13:0]      snipe_prod;
	logic [16:0]      def_sum, snipe_sum;
	logic [15:0]      def_res, snipe_res, res_n;

	// Take a new word whenever the input register is empty or moves on.
	assign out_free = !vld_s2 || !out_stall;
	assign adv_s1   = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	assign ax_h = drag_axis(acc_h_q, dx_s1, reverse_q[0], thresh_q);
	assign ax_v = drag_axis(acc_v_q, dy_s1, reverse_q[1], thresh_q);

	always_comb begin
		def_idx_n    = def_idx_q;
		snipe_idx_n  = snipe_idx_q;
		snipe_flag_n = snipe_flag_q;
		drag_flag_n  = drag_flag_q;
		acc_h_n      = acc_h_q;
		acc_v_n      = acc_v_q;
		ox = '0;
		oy = '0;
		oh = '0;
		ov = '0;
		unique case (op_s1)
			OP_MOTION: begin
				if (drag_flag_q) begin
					acc_h_n = ax_h.acc;
					acc_v_n = ax_v.acc;
					oh = ax_h.emit ? (ax_h.neg ? 8'hFF : 8'h01) : wh_s1;
					ov = ax_v.emit ? (ax_v.neg ? 8'hFF : 8'h01) : wv_s1;
				end else begin
					ox = dx_s1;
					oy = dy_s1;
					oh = wh_s1;
					ov = wv_s1;
				end
			end
			OP_STEP_DEF: begin
				if (prs_s1)
					def_idx_n = fwd_s1 ? def_idx_q + 4'd1 : def_idx_q - 4'd1;
			end
			OP_STEP_SNIPE: begin
				if (prs_s1)
					snipe_idx_n = fwd_s1 ? snipe_idx_q + 2'd1 : snipe_idx_q - 2'd1;
			end
			OP_SET_SNIPE: snipe_flag_n = prs_s1;
			OP_TOG_SNIPE: snipe_flag_n = snipe_flag_q ^ prs_s1;
			OP_SET_DRAG:  drag_flag_n = prs_s1;
			OP_TOG_DRAG:  drag_flag_n = drag_flag_q ^ prs_s1;
			default: ;
		endcase
	end

	// Effective resolution after this word: drag, then sniping, then default.
	always_comb begin
		def_prod   = {12'd0, def_idx_n} * {4'd0, def_step_q};
		snipe_prod = {12'd0, snipe_idx_n} * {2'd0, snipe_step_q};
		def_sum    = {1'b0, def_base_q} + {1'b0, def_prod};
		snipe_sum  = {1'b0, snipe_base_q} + {3'd0, snipe_prod};
		def_res    = def_sum[16] ? 16'hFFFF : def_sum[15:0];
		snipe_res  = snipe_sum[16] ? 16'hFFFF : snipe_sum[15:0];
		priority if (drag_flag_n)
			res_n = drag_res_q;
		else if (snipe_flag_n)
			res_n = snipe_res;
		else
			res_n = def_res;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_base_q   <= RST_DEF_BASE;
			def_step_q   <= RST_DEF_STEP;
			snipe_base_q <= RST_SNIPE_BASE;
			snipe_step_q <= RST_SNIPE_STEP;
			drag_res_q   <= RST_DRAG_RES;
			thresh_q     <= RST_THRESHOLD;
			reverse_q    <= RST_REVERSE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEF_BASE:   def_base_q   <= cfg_wdata;
				REG_DEF_STEP:   def_step_q   <= cfg_wdata[11:0];
				REG_SNIPE_BASE: snipe_base_q <= cfg_wdata;
				REG_SNIPE_STEP: snipe_step_q <= cfg_wdata[11:0];
				REG_DRAG_RES:   drag_res_q   <= cfg_wdata;
				REG_THRESHOLD:  thresh_q     <= cfg_wdata[7:0];
				REG_REVERSE:    reverse_q    <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Mode state: advance once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_idx_q    <= '0;
			snipe_idx_q  <= '0;
			snipe_flag_q <= 1'b0;
			drag_flag_q  <= 1'b0;
			acc_h_q      <= '0;
			acc_v_q      <= '0;
		end else if (adv_s1) begin
			def_idx_q    <= def_idx_n;
			snipe_idx_q  <= snipe_idx_n;
			snipe_flag_q <= snipe_flag_n;
			drag_flag_q  <= drag_flag_n;
			acc_h_q      <= acc_h_n;
			acc_v_q      <= acc_v_n;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_in)
				vld_s1 <= 1'b1;
			else if (adv_s1)
				vld_s1 <= 1'b0;
			if (adv_s1)
				vld_s2 <= 1'b1;
			else if (!out_stall)
				vld_s2 <= 1'b0;
		end
	end

	// Payload: load input word on accept, hold result while stalled
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1  <= opcode;
			fwd_s1 <= forward;
			prs_s1 <= pressed;
			dx_s1  <= dx;
			dy_s1  <= dy;
			wh_s1  <= wheel_h_in;
			wv_s1  <= wheel_v_in;
		end
		if (adv_s1) begin
			res_s2   <= res_n;
			x_s2     <= ox;
			y_s2     <= oy;
			h_s2     <= oh;
			v_s2     <= ov;
			snipe_s2 <= snipe_flag_n;
			drag_s2  <= drag_flag_n;
			didx_s2  <= def_idx_n;
			sidx_s2  <= snipe_idx_n;
		end
	end

	assign out_valid     = vld_s2;
	assign resolution    = res_s2;
	assign out_x         = x_s2;
	assign out_y         = y_s2;
	assign out_h         = h_s2;
	assign out_v         = v_s2;
	assign sniping_on    = snipe_s2;
	assign drag_on       = drag_s2;
	assign default_index = didx_s2;
	assign sniping_index = sidx_s2;

endmodule

`default_nettype wire

// ----- sv/prp_checker.sv -----
`default_nettype none

module prp_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [15:0]           resolution,
	input wire logic [7:0]            out_x,
	input wire logic [7:0]            out_y,
	input wire logic [7:0]            out_h,
	input wire logic [7:0]            out_v,
	input wire logic                  drag_on,
	input wire logic [3:0]            default_index,
	input wire logic [1:0]            sniping_index
);

	logic       in_take, out_take;
	logic [1:0] pend_q;
	logic       have_prev_q;
	logic [3:0] prev_didx_q;
	logic [1:0] prev_sidx_q;
	logic       d_same, s_same, d_step, s_step;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// Words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_take && !out_take) begin
			pend_q <= pend_q + 2'd1;
		end else if (!in_take && out_take) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// Indices seen in the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_didx_q <= '0;
			prev_sidx_q <= '0;
		end else if (out_take) begin
			have_prev_q <= 1'b1;
			prev_didx_q <= default_index;
			prev_sidx_q <= sniping_index;
		end
	end

	assign d_same = default_index == prev_didx_q;
	assign s_same = sniping_index == prev_sidx_q;
	assign d_step = default_index == prev_didx_q + 4'd1
		|| default_index == prev_didx_q - 4'd1;
	assign s_step = sniping_index == prev_sidx_q + 2'd1
		|| sniping_index == prev_sidx_q - 2'd1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(resolution)
		&& $stable(out_h) && $stable(out_v) && $stable(default_index))
		else $error("stalled result word changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0 && pend_q != 2'd3)
		else $error("result word without a pending input word");

	a_drag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drag_on |-> out_x == 8'd0 && out_y == 8'd0)
		else $error("motion passed on in drag mode");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && have_prev_q |-> (d_same && (s_same || s_step))
		|| (s_same && d_step))
		else $error("index moved by more than one step per word");

endmodule

bind pointer_resolution_and_drag_scroll prp_checker u_prp_checker (.*);

`default_nettype wire
